>>> src/inactivity_power_sequencer_macros.svh
// Assertion macros for the inactivity power sequencer.
`ifndef INACTIVITY_POWER_SEQUENCER_MACROS_SVH
`define INACTIVITY_POWER_SEQUENCER_MACROS_SVH
`ifndef SYNTH
`define IPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IPS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/ips_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ips_pkg;

    localparam logic [31:0] DEF_DISPLAY_MS = 32'd60000;
    localparam logic [31:0] DEF_DEEP_MS = 32'd900000;
    localparam logic [31:0] MIN_DEEP_AFTER_MS = 32'd60000;
    localparam logic [7:0] DEF_THRESHOLD = 8'd35;
    localparam logic [13:0] OFF_DELTA_MIN = 14'd55;
    localparam logic [31:0] OFF_GRACE_MS = 32'd600;
    localparam logic [31:0] OFF_POLL_MS = 32'd150;
    localparam logic [31:0] OFF_WAKE_GAP_MS = 32'd400;

    typedef enum logic [2:0]
    {
        REG_DISPLAY = 3'd0,
        REG_DEEP = 3'd1,
        REG_DIM_LEAD = 3'd2,
        REG_THRESHOLD = 3'd3,
        REG_WAKE_EN = 3'd4,
        REG_SENSOR = 3'd5
    } reg_index_t;

    typedef struct packed
    {
        logic [31:0] now_ms;
        logic user_activity;
        logic motion_int_active;
        logic signed [11:0] accel_x;
        logic signed [11:0] accel_y;
        logic signed [11:0] accel_z;
    } in_item_t;

    typedef struct packed
    {
        logic screen_is_off;
        logic dim_start;
        logic screen_off_event;
        logic screen_on_event;
        logic motion_seen;
        logic deep_sleep_request;
        logic [31:0] idle_time_ms;
    } out_item_t;

    typedef struct packed
    {
        logic [2:0] index;
        logic [31:0] data;
    } cfg_beat_t;

    // Poll after front-end decoding: time stamp, activity flags and the signed samples.
    typedef struct packed
    {
        logic [31:0] now_ms;
        logic user_activity;
        logic motion_int_active;
        logic signed [11:0] ax;
        logic signed [11:0] ay;
        logic signed [11:0] az;
    } poll_t;

    typedef struct packed
    {
        logic [31:0] disp;
        logic [31:0] deep;
        logic [31:0] dim_lo;
        logic dim_ok;
        logic [7:0] thresh;
        logic motion_en;
        logic sensor;
    } limits_t;

    function automatic logic [11:0] absdiff12(input logic signed [11:0] a,
                                              input logic signed [11:0] b);
        logic signed [12:0] d;
        begin
            d = 13'(signed'(a)) - 13'(signed'(b));
            absdiff12 = d[12] ? 12'(-d) : 12'(d);
        end
    endfunction

endpackage
`default_nettype wire

>>> src/inactivity_power_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// A poll is registered in the front register, then its result in the result register.
// Throughput: one poll per cycle while out_ready holds; a low out_ready stalls both registers.
// The state update in the back end, made as each poll fires, sets the rate.
// Reset (rst_n low, asynchronous) restores register defaults, display on, no sleep request.
module inactivity_power_sequencer
    import ips_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire cfg_beat_t cfg,
    input wire logic cfg_valid,
    output logic cfg_ready,
    input wire in_item_t in_data,
    input wire logic in_valid,
    output logic in_ready,
    output out_item_t out_data,
    output logic out_valid,
    input wire logic out_ready
);

    poll_t q_data;
    limits_t q_lim;
    logic q_valid;
    logic q_ready;

    ips_front u_front
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .in_data(in_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .q_data(q_data),
        .q_lim(q_lim),
        .q_valid(q_valid),
        .q_ready(q_ready)
    );

    ips_back u_back
    (
        .clk(clk),
        .rst_n(rst_n),
        .p(q_data),
        .lim(q_lim),
        .p_valid(q_valid),
        .p_ready(q_ready),
        .out_data(out_data),
        .out_valid(out_valid),
        .out_ready(out_ready)
    );

endmodule
`default_nettype wire

>>> src/ips_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ips_front
    import ips_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire cfg_beat_t cfg,
    input wire logic cfg_valid,
    output logic cfg_ready,
    input wire in_item_t in_data,
    input wire logic in_valid,
    output logic in_ready,
    output poll_t q_data,
    output limits_t q_lim,
    output logic q_valid,
    input wire logic q_ready
);

    logic [26:0] disp_reg;
    logic [27:0] deep_reg;
    logic [15:0] dim_reg;
    logic [7:0] thr_reg;
    logic wake_reg;
    logic sensor_reg;
    logic [31:0] eff_disp;
    logic [31:0] eff_deep_raw;
    logic [31:0] eff_deep_min;
    limits_t lim;
    poll_t poll;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_reg <= 27'd60000;
            deep_reg <= 28'd900000;
            dim_reg <= 16'd2000;
            thr_reg <= 8'd35;
            wake_reg <= 1'b1;
            sensor_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg.index)
                REG_DISPLAY: disp_reg <= cfg.data[26:0];
                REG_DEEP: deep_reg <= cfg.data[27:0];
                REG_DIM_LEAD: dim_reg <= cfg.data[15:0];
                REG_THRESHOLD: thr_reg <= cfg.data[7:0];
                REG_WAKE_EN: wake_reg <= cfg.data[0];
                REG_SENSOR: sensor_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        eff_disp = (disp_reg == '0) ? DEF_DISPLAY_MS : 32'(disp_reg);
        eff_deep_raw = (deep_reg == '0) ? DEF_DEEP_MS : 32'(deep_reg);
        eff_deep_min = eff_disp + MIN_DEEP_AFTER_MS;
        lim.disp = eff_disp;
        lim.deep = (eff_deep_raw < eff_deep_min) ? eff_deep_min : eff_deep_raw;
        lim.dim_ok = eff_disp > 32'(dim_reg);
        lim.dim_lo = eff_disp - 32'(dim_reg);
        lim.thresh = (thr_reg == '0) ? DEF_THRESHOLD : thr_reg;
        lim.motion_en = wake_reg;
        lim.sensor = sensor_reg;
        poll.now_ms = in_data.now_ms;
        poll.user_activity = in_data.user_activity;
        poll.motion_int_active = in_data.motion_int_active;
        poll.ax = in_data.accel_x;
        poll.ay = in_data.accel_y;
        poll.az = in_data.accel_z;
    end

    assign in_ready = !q_valid || q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid <= 1'b0;
        end
        else if (in_ready)
        begin
            q_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            q_data <= poll;
            q_lim <= lim;
        end
    end

endmodule
`default_nettype wire

>>> src/ips_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "inactivity_power_sequencer_macros.svh"
module ips_back
    import ips_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire poll_t p,
    input wire limits_t lim,
    input wire logic p_valid,
    output logic p_ready,
    output out_item_t out_data,
    output logic out_valid,
    input wire logic out_ready
);

    logic [31:0] last_act_reg, last_act_next;
    logic off_reg, off_next;
    logic dim_done_reg, dim_done_next;
    logic rebase_reg, rebase_next;
    logic signed [11:0] prev_reg [3];
    logic signed [11:0] prev_next [3];
    logic signed [11:0] base_reg [3];
    logic signed [11:0] base_next [3];
    logic [31:0] off_since_reg, off_since_next;
    logic [31:0] poll_t_reg, poll_t_next;
    logic [31:0] wake_t_reg, wake_t_next;
    logic rearm_reg, rearm_next;
    logic sleep_reg, sleep_next;
    logic signed [11:0] s [3];
    logic on_evt, motion_flag, dim_evt, off_evt;
    logic [31:0] idle0, idle;
    logic [13:0] sum_off, sum_on;
    logic act;
    logic fire;
    out_item_t res;

    assign p_ready = !out_valid || out_ready;
    assign fire = p_valid && p_ready;

    always_comb
    begin
        s[0] = p.ax;
        s[1] = p.ay;
        s[2] = p.az;
        last_act_next = last_act_reg;
        off_next = off_reg;
        dim_done_next = dim_done_reg;
        rebase_next = rebase_reg;
        prev_next = prev_reg;
        base_next = base_reg;
        off_since_next = off_since_reg;
        poll_t_next = poll_t_reg;
        wake_t_next = wake_t_reg;
        rearm_next = rearm_reg;
        sleep_next = sleep_reg;
        on_evt = 1'b0;
        motion_flag = 1'b0;
        dim_evt = 1'b0;
        off_evt = 1'b0;
        act = p.user_activity;
        sum_off = 14'(absdiff12(base_reg[0], s[0])) + 14'(absdiff12(base_reg[1], s[1]))
            + 14'(absdiff12(base_reg[2], s[2]));
        sum_on = 14'(absdiff12(prev_reg[0], s[0])) + 14'(absdiff12(prev_reg[1], s[1]))
            + 14'(absdiff12(prev_reg[2], s[2]));
        // The motion check sees the state left by user activity.
        if (act)
        begin
            last_act_next = p.now_ms;
            dim_done_next = 1'b0;
            if (off_reg)
            begin
                off_next = 1'b0;
                on_evt = 1'b1;
            end
        end
        idle0 = p.now_ms - last_act_next;
        if (lim.sensor && lim.motion_en
            && !(!off_next && lim.dim_ok && idle0 >= lim.dim_lo && idle0 < lim.disp))
        begin
            if (off_next)
            begin
                if (p.now_ms - off_since_reg >= OFF_GRACE_MS
                    && p.now_ms - poll_t_reg >= OFF_POLL_MS)
                begin
                    poll_t_next = p.now_ms;
                    if (!p.motion_int_active)
                    begin
                        rearm_next = 1'b1;
                    end
                    else if (rearm_reg && p.now_ms - wake_t_reg > OFF_WAKE_GAP_MS
                             && sum_off >= OFF_DELTA_MIN)
                    begin
                        wake_t_next = p.now_ms;
                        rearm_next = 1'b0;
                        last_act_next = p.now_ms;
                        dim_done_next = 1'b0;
                        off_next = 1'b0;
                        on_evt = 1'b1;
                        motion_flag = 1'b1;
                    end
                end
            end
            else if (rebase_reg)
            begin
                prev_next = s;
                rebase_next = 1'b0;
            end
            else
            begin
                prev_next = s;
                if (sum_on > 14'(lim.thresh))
                begin
                    last_act_next = p.now_ms;
                    dim_done_next = 1'b0;
                    motion_flag = 1'b1;
                end
            end
        end
        idle = p.now_ms - last_act_next;
        if (!off_next)
        begin
            if (lim.dim_ok && idle >= lim.dim_lo && idle < lim.disp && !dim_done_next)
            begin
                dim_done_next = 1'b1;
                dim_evt = 1'b1;
            end
            if (idle >= lim.disp)
            begin
                off_next = 1'b1;
                off_evt = 1'b1;
                dim_done_next = 1'b0;
                rebase_next = 1'b1;
                wake_t_next = '0;
                off_since_next = p.now_ms;
                rearm_next = 1'b0;
                if (lim.sensor)
                begin
                    base_next = s;
                end
            end
        end
        if (idle >= lim.deep)
        begin
            sleep_next = 1'b1;
        end
        res.screen_is_off = off_next;
        res.dim_start = dim_evt;
        res.screen_off_event = off_evt;
        res.screen_on_event = on_evt;
        res.motion_seen = motion_flag;
        res.deep_sleep_request = sleep_next;
        res.idle_time_ms = idle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_act_reg <= '0;
            off_reg <= 1'b0;
            dim_done_reg <= 1'b0;
            rebase_reg <= 1'b0;
            prev_reg <= '{default: '0};
            base_reg <= '{default: '0};
            off_since_reg <= '0;
            poll_t_reg <= '0;
            wake_t_reg <= '0;
            rearm_reg <= 1'b0;
            sleep_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (p_ready)
            begin
                out_valid <= p_valid;
            end
            if (fire)
            begin
                last_act_reg <= last_act_next;
                off_reg <= off_next;
                dim_done_reg <= dim_done_next;
                rebase_reg <= rebase_next;
                prev_reg <= prev_next;
                base_reg <= base_next;
                off_since_reg <= off_since_next;
                poll_t_reg <= poll_t_next;
                wake_t_reg <= wake_t_next;
                rearm_reg <= rearm_next;
                sleep_reg <= sleep_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data <= res;
        end
    end

    `IPS_ASSERT_NEXT(a_sleep_held, clk, rst_n, sleep_reg, sleep_reg)
    `IPS_ASSERT_IMPL(a_on_off_excl, clk, rst_n, fire, !(res.screen_on_event && res.screen_off_event))
    `IPS_ASSERT_IMPL(a_on_needs_off, clk, rst_n, fire && res.screen_on_event, off_reg)
    `IPS_ASSERT_NEXT(a_off_sets_rebase, clk, rst_n, fire && res.screen_off_event, off_reg && rebase_reg)

endmodule
`default_nettype wire
